### hdl/owo_pkg.sv
// ----------------------------------------------------------------------------
// owo_pkg: shared definitions for the omni wheel odometry block
// Widths, reset values, the CORDIC arctangent table and the command struct
// that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package owo_pkg;

  // Field widths.
  localparam int DeltaW = 16;
  localparam int DistW  = 16;
  localparam int StepW  = 21;
  localparam int PosW   = 32;
  localparam int AngW   = 32;

  // Internal widths.
  localparam int DiffW  = DeltaW + 1;  // d0 - d2, d1 - d3
  localparam int SumW   = DeltaW + 2;  // d0 + d1 + d2 + d3
  localparam int TrigW  = 32;          // CORDIC x, y, z
  localparam int AccW   = 50;          // rotated sum in Q30 counts
  localparam int MulAW  = 36;
  localparam int MulBW  = 21;
  localparam int ProdW  = MulAW + MulBW;

  // Iteration count limits and default.
  localparam int TrigIterationsDef = 16;
  localparam int AtanEntries       = 30;
  localparam int AtanIdxW          = 5;

  // 0.6072529350 in Q1.30.
  localparam logic signed [TrigW-1:0] CordicInvGain = 32'sd652032874;

  // Register reset values.
  localparam logic [DistW-1:0]        DistanceScaleReset = 16'd13107;
  localparam logic signed [StepW-1:0] HeadingStepReset   = -21'sd143166;

  // Register indexes, taken from the word address.
  localparam logic RegDistanceScale = 1'b0;
  localparam logic RegHeadingStep   = 1'b1;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [TrigW-1:0] atan_turn(input logic [AtanIdxW-1:0] idx);
    logic [TrigW-1:0] val;
    case (idx)
      5'd0:  val = 32'h2000_0000;
      5'd1:  val = 32'h12E4_051E;
      5'd2:  val = 32'h09FB_385B;
      5'd3:  val = 32'h0511_11D4;
      5'd4:  val = 32'h028B_0D43;
      5'd5:  val = 32'h0145_D7E1;
      5'd6:  val = 32'h00A2_F61E;
      5'd7:  val = 32'h0051_7C55;
      5'd8:  val = 32'h0028_BE53;
      5'd9:  val = 32'h0014_5F2F;
      5'd10: val = 32'h000A_2F98;
      5'd11: val = 32'h0005_17CC;
      5'd12: val = 32'h0002_8BE6;
      5'd13: val = 32'h0001_45F3;
      5'd14: val = 32'h0000_A2FA;
      5'd15: val = 32'h0000_517D;
      5'd16: val = 32'h0000_28BE;
      5'd17: val = 32'h0000_145F;
      5'd18: val = 32'h0000_0A30;
      5'd19: val = 32'h0000_0518;
      5'd20: val = 32'h0000_028C;
      5'd21: val = 32'h0000_0146;
      5'd22: val = 32'h0000_00A3;
      5'd23: val = 32'h0000_0051;
      5'd24: val = 32'h0000_0029;
      5'd25: val = 32'h0000_0014;
      5'd26: val = 32'h0000_000A;
      5'd27: val = 32'h0000_0005;
      5'd28: val = 32'h0000_0003;
      5'd29: val = 32'h0000_0001;
      default: val = '0;
    endcase
    return val;
  endfunction

  // Operand pair for the shared multiplier.
  typedef enum logic [2:0] {
    MUL_A_COS,
    MUL_B_SIN,
    MUL_A_SIN,
    MUL_B_COS,
    MUL_X_SCALE,
    MUL_Y_SCALE,
    MUL_TURN
  } mul_sel_e;

  // Accumulator operation.
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_ROUND,
    ACC_STEP
  } acc_op_e;

  typedef struct packed {
    logic     load;
    logic     cordic;
    logic     map;
    mul_sel_e mul_sel;
    acc_op_e  x_op;
    acc_op_e  y_op;
    logic     x_sat;
    logic     y_sat;
    logic     hd_upd;
    logic     out_load;
  } dp_cmd_t;

endpackage

### hdl/omni_wheel_odometry_top.sv
// ----------------------------------------------------------------------------
// omni_wheel_odometry_top: four wheel omni odometry
// Integrates encoder deltas from four omni wheels into a saturating x/y
// position and a wrapping binary angle heading.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake             | Payload
//   ---------+-----------------------+-------------------------------------
//   input    | in_valid_i/in_stall_o | wheel0_delta_i .. wheel3_delta_i
//   output   | out_valid_o/out_stall_i | pos_x_o, pos_y_o, heading_o
//   config   | psel/penable/pready   | paddr, pwdata, prdata
//
// An item passes through the CORDIC iterations, one per cycle, the quadrant
// map and the nine steps through the single shared multiplier in that order.
// Reset is asynchronous and active low; it clears the pose to zero and loads
// the register defaults. A new beat is accepted as soon as the previous item
// has reached the output register, even while that result is stalled; the
// next result then waits in the datapath until the output register frees up.
//
module omni_wheel_odometry_top #(
  parameter int TrigIterations = owo_pkg::TrigIterationsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input channel.
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [owo_pkg::DeltaW-1:0]    wheel0_delta_i,
  input  logic signed [owo_pkg::DeltaW-1:0]    wheel1_delta_i,
  input  logic signed [owo_pkg::DeltaW-1:0]    wheel2_delta_i,
  input  logic signed [owo_pkg::DeltaW-1:0]    wheel3_delta_i,
  // Output channel.
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [owo_pkg::PosW-1:0]      pos_x_o,
  output logic signed [owo_pkg::PosW-1:0]      pos_y_o,
  output logic [owo_pkg::AngW-1:0]             heading_o,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int IterW = $clog2(TrigIterations);

  owo_pkg::dp_cmd_t                 cmd;
  logic [IterW-1:0]                 iter;
  logic [owo_pkg::DistW-1:0]        distance_scale;
  logic signed [owo_pkg::StepW-1:0] heading_step;

  // Register file. The user must let writes land only while the block is idle;
  // the block does not enforce this, and the datapath reads the registers directly.
  owo_regs u_regs (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .distance_scale_o (distance_scale),
    .heading_step_o   (heading_step)
  );

  // The controller sequences the load, the CORDIC iterations, the quadrant
  // map and the multiply schedule, then hands the pose to the output register.
  owo_ctrl #(
    .TrigIterations (TrigIterations)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .iter_o      (iter)
  );

  // The datapath rotates the wheel differences by the heading from before the
  // item, so the heading update is scheduled after the rotation products.
  owo_dp #(
    .TrigIterations (TrigIterations)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .iter_i           (iter),
    .wheel0_delta_i   (wheel0_delta_i),
    .wheel1_delta_i   (wheel1_delta_i),
    .wheel2_delta_i   (wheel2_delta_i),
    .wheel3_delta_i   (wheel3_delta_i),
    .distance_scale_i (distance_scale),
    .heading_step_i   (heading_step),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .heading_o        (heading_o)
  );

`ifndef SYNTHESIS
  // An accepted beat makes the block busy on the next cycle.
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o
  ) else $error("block not busy after an input beat");

  // A fresh result only appears after the block has been working on an item.
  a_result_after_work: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o)
  ) else $error("result raised without a preceding item");

  // Handing over a result returns the controller to idle at the same edge.
  a_idle_on_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o
  ) else $error("controller still busy after handing over a result");
`endif

endmodule

### hdl/owo_regs.sv
// ----------------------------------------------------------------------------
// owo_regs: configuration registers
// APB-style register file holding the distance scale and the heading step.
// ----------------------------------------------------------------------------
module owo_regs (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [2:0]                               paddr,
  input  logic [31:0]                              pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready,
  output logic [owo_pkg::DistW-1:0]                distance_scale_o,
  output logic signed [owo_pkg::StepW-1:0]         heading_step_o
);

  logic [owo_pkg::DistW-1:0]        distance_scale_q;
  logic signed [owo_pkg::StepW-1:0] heading_step_q;
  logic                             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      distance_scale_q <= owo_pkg::DistanceScaleReset;
      heading_step_q   <= owo_pkg::HeadingStepReset;
    end else if (wr_en) begin
      case (paddr[2])
        owo_pkg::RegDistanceScale: distance_scale_q <= pwdata[owo_pkg::DistW-1:0];
        owo_pkg::RegHeadingStep:   heading_step_q   <= pwdata[owo_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      owo_pkg::RegDistanceScale: prdata = {{(32 - owo_pkg::DistW){1'b0}}, distance_scale_q};
      owo_pkg::RegHeadingStep:
        prdata = {{(32 - owo_pkg::StepW){heading_step_q[owo_pkg::StepW-1]}}, heading_step_q};
      default: prdata = '0;
    endcase
  end

  assign distance_scale_o = distance_scale_q;
  assign heading_step_o   = heading_step_q;

endmodule

### hdl/owo_ctrl.sv
// ----------------------------------------------------------------------------
// owo_ctrl: sequencer for the odometry datapath
// Steps the CORDIC iterations, the quadrant map, then the multiply and accumulate schedule,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module owo_ctrl #(
  parameter int TrigIterations = owo_pkg::TrigIterationsDef,
  localparam int IterW = $clog2(TrigIterations)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output owo_pkg::dp_cmd_t cmd_o,
  output logic [IterW-1:0] iter_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MAP,
    ST_MATH,
    ST_DONE
  } state_e;

  localparam logic [IterW-1:0] IterLast = IterW'(TrigIterations - 1);
  localparam logic [3:0]       SeqLast  = 4'd8;

  state_e           state_q;
  logic [IterW-1:0] iter_q;
  logic [3:0]       seq_q;
  logic             out_valid_q;

  // Command decode. The multiply and accumulate schedule keeps one product
  // in flight: the product issued in one step is consumed in the next.
  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_sel  = owo_pkg::MUL_A_COS;
    cmd_o.x_op     = owo_pkg::ACC_HOLD;
    cmd_o.y_op     = owo_pkg::ACC_HOLD;
    case (state_q)
      ST_IDLE:   cmd_o.load   = in_valid_i;
      ST_CORDIC: cmd_o.cordic = 1'b1;
      ST_MAP:    cmd_o.map    = 1'b1;
      ST_MATH: begin
        case (seq_q)
          4'd0: cmd_o.mul_sel = owo_pkg::MUL_A_COS;
          4'd1: begin
            cmd_o.mul_sel = owo_pkg::MUL_B_SIN;
            cmd_o.x_op    = owo_pkg::ACC_LOAD;
          end
          4'd2: begin
            cmd_o.mul_sel = owo_pkg::MUL_A_SIN;
            cmd_o.x_op    = owo_pkg::ACC_SUB;
          end
          4'd3: begin
            cmd_o.mul_sel = owo_pkg::MUL_B_COS;
            cmd_o.y_op    = owo_pkg::ACC_LOAD;
            cmd_o.x_op    = owo_pkg::ACC_ROUND;
          end
          4'd4: begin
            cmd_o.mul_sel = owo_pkg::MUL_X_SCALE;
            cmd_o.y_op    = owo_pkg::ACC_ADD;
          end
          4'd5: begin
            cmd_o.mul_sel = owo_pkg::MUL_TURN;
            cmd_o.y_op    = owo_pkg::ACC_ROUND;
            cmd_o.x_op    = owo_pkg::ACC_STEP;
          end
          4'd6: begin
            cmd_o.mul_sel = owo_pkg::MUL_Y_SCALE;
            cmd_o.x_sat   = 1'b1;
            cmd_o.hd_upd  = 1'b1;
          end
          4'd7: cmd_o.y_op  = owo_pkg::ACC_STEP;
          4'd8: cmd_o.y_sat = 1'b1;
          default: ;
        endcase
      end
      ST_DONE: cmd_o.out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // In ST_DONE a departing result is replaced at the same edge.
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            iter_q  <= '0;
            state_q <= ST_CORDIC;
          end
        end
        ST_CORDIC: begin
          if (iter_q == IterLast) begin
            state_q <= ST_MAP;
          end else begin
            iter_q <= iter_q + 1'b1;
          end
        end
        ST_MAP: begin
          seq_q   <= '0;
          state_q <= ST_MATH;
        end
        ST_MATH: begin
          if (seq_q == SeqLast) begin
            state_q <= ST_DONE;
          end else begin
            seq_q <= seq_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign iter_o      = iter_q;

endmodule

### hdl/owo_dp.sv
// ----------------------------------------------------------------------------
// owo_dp: odometry datapath
// CORDIC sine and cosine, one shared multiplier with two accumulators,
// saturating position registers, the heading register and the result register.
// ----------------------------------------------------------------------------
module owo_dp #(
  parameter int TrigIterations = owo_pkg::TrigIterationsDef,
  localparam int IterW = $clog2(TrigIterations)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  owo_pkg::dp_cmd_t                     cmd_i,
  input  logic [IterW-1:0]                     iter_i,
  input  logic signed [owo_pkg::DeltaW-1:0]    wheel0_delta_i,
  input  logic signed [owo_pkg::DeltaW-1:0]    wheel1_delta_i,
  input  logic signed [owo_pkg::DeltaW-1:0]    wheel2_delta_i,
  input  logic signed [owo_pkg::DeltaW-1:0]    wheel3_delta_i,
  input  logic [owo_pkg::DistW-1:0]            distance_scale_i,
  input  logic signed [owo_pkg::StepW-1:0]     heading_step_i,
  output logic signed [owo_pkg::PosW-1:0]      pos_x_o,
  output logic signed [owo_pkg::PosW-1:0]      pos_y_o,
  output logic [owo_pkg::AngW-1:0]             heading_o
);

  localparam int AccW  = owo_pkg::AccW;
  localparam int ProdW = owo_pkg::ProdW;
  localparam int TrigW = owo_pkg::TrigW;
  localparam int PosW  = owo_pkg::PosW;
  localparam int SatW  = PosW + 2;

  localparam logic signed [AccW-1:0]  RoundQ16  = AccW'(64'sd8192);
  localparam logic signed [ProdW-1:0] RoundStep = ProdW'(64'sd8388608);
  localparam logic [owo_pkg::AngW-1:0] EighthTurn = 32'h2000_0000;

  // Item operands.
  logic signed [owo_pkg::DiffW-1:0] a_q, b_q;
  logic signed [owo_pkg::SumW-1:0]  sum_q;

  // CORDIC state; after the map step cx_q holds cos and cy_q holds sin.
  logic signed [TrigW-1:0] cx_q, cy_q, cz_q;
  logic [1:0]              quad_q;

  logic signed [AccW-1:0]  acc_x_q, acc_y_q;
  logic signed [ProdW-1:0] prod_q;

  logic signed [PosW-1:0]          px_q, py_q;
  logic [owo_pkg::AngW-1:0]        hd_q;
  logic signed [PosW-1:0]          ox_q, oy_q;
  logic [owo_pkg::AngW-1:0]        oh_q;

  // Load decode.
  logic signed [owo_pkg::DiffW-1:0] a_d, b_d;
  logic signed [owo_pkg::SumW-1:0]  sum_d;
  logic [owo_pkg::AngW-1:0]         hd_biased;
  logic [1:0]                       quad_d;
  logic [owo_pkg::AngW-1:0]         resid_d;

  assign a_d = owo_pkg::DiffW'(wheel0_delta_i) - owo_pkg::DiffW'(wheel2_delta_i);
  assign b_d = owo_pkg::DiffW'(wheel1_delta_i) - owo_pkg::DiffW'(wheel3_delta_i);
  assign sum_d = owo_pkg::SumW'(wheel0_delta_i) + owo_pkg::SumW'(wheel1_delta_i)
               + owo_pkg::SumW'(wheel2_delta_i) + owo_pkg::SumW'(wheel3_delta_i);
  assign hd_biased = hd_q + EighthTurn;
  assign quad_d    = hd_biased[owo_pkg::AngW-1 -: 2];
  assign resid_d   = hd_q - {quad_d, {(owo_pkg::AngW - 2){1'b0}}};

  // One CORDIC rotation; the sign of the residual angle picks the direction.
  logic signed [TrigW-1:0] x_sh, y_sh;
  logic [TrigW-1:0]        atan_val;

  assign x_sh     = cx_q >>> iter_i;
  assign y_sh     = cy_q >>> iter_i;
  assign atan_val = owo_pkg::atan_turn(owo_pkg::AtanIdxW'(iter_i));

  // Shared multiplier operands.
  logic signed [owo_pkg::MulAW-1:0] mul_a;
  logic signed [owo_pkg::MulBW-1:0] mul_b;
  logic signed [ProdW-1:0]          mul_a_ext, mul_b_ext, prod_d;

  always_comb begin
    case (cmd_i.mul_sel)
      owo_pkg::MUL_A_COS: begin
        mul_a = owo_pkg::MulAW'(cx_q);
        mul_b = owo_pkg::MulBW'(a_q);
      end
      owo_pkg::MUL_B_SIN: begin
        mul_a = owo_pkg::MulAW'(cy_q);
        mul_b = owo_pkg::MulBW'(b_q);
      end
      owo_pkg::MUL_A_SIN: begin
        mul_a = owo_pkg::MulAW'(cy_q);
        mul_b = owo_pkg::MulBW'(a_q);
      end
      owo_pkg::MUL_B_COS: begin
        mul_a = owo_pkg::MulAW'(cx_q);
        mul_b = owo_pkg::MulBW'(b_q);
      end
      owo_pkg::MUL_X_SCALE: begin
        mul_a = acc_x_q[owo_pkg::MulAW-1:0];
        mul_b = $signed({{(owo_pkg::MulBW - owo_pkg::DistW){1'b0}}, distance_scale_i});
      end
      owo_pkg::MUL_Y_SCALE: begin
        mul_a = acc_y_q[owo_pkg::MulAW-1:0];
        mul_b = $signed({{(owo_pkg::MulBW - owo_pkg::DistW){1'b0}}, distance_scale_i});
      end
      owo_pkg::MUL_TURN: begin
        mul_a = owo_pkg::MulAW'(sum_q);
        mul_b = heading_step_i;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_a_ext = ProdW'(mul_a);
  assign mul_b_ext = ProdW'(mul_b);
  assign prod_d    = mul_a_ext * mul_b_ext;

  // Accumulator update shared by both axes.
  logic signed [AccW-1:0]  prod_acc;
  logic signed [ProdW-1:0] prod_round;
  logic signed [AccW-1:0]  step_val;

  assign prod_acc   = prod_q[AccW-1:0];
  assign prod_round = (prod_q + RoundStep) >>> 24;
  assign step_val   = prod_round[AccW-1:0];

  function automatic logic signed [AccW-1:0] acc_next(
    input owo_pkg::acc_op_e  op,
    input logic signed [AccW-1:0] acc,
    input logic signed [AccW-1:0] prod,
    input logic signed [AccW-1:0] step
  );
    logic signed [AccW-1:0] res;
    case (op)
      owo_pkg::ACC_LOAD:  res = prod;
      owo_pkg::ACC_ADD:   res = acc + prod;
      owo_pkg::ACC_SUB:   res = acc - prod;
      owo_pkg::ACC_ROUND: res = (acc + RoundQ16) >>> 14;
      owo_pkg::ACC_STEP:  res = step;
      default:            res = acc;
    endcase
    return res;
  endfunction

  // Saturating position add.
  function automatic logic signed [PosW-1:0] sat_add(
    input logic signed [PosW-1:0] base,
    input logic signed [AccW-1:0] step
  );
    logic signed [SatW-1:0] sum;
    logic signed [PosW-1:0] res;
    sum = SatW'(base) + step[SatW-1:0];
    if (sum[SatW-1:PosW-1] == '0 || sum[SatW-1:PosW-1] == '1) begin
      res = sum[PosW-1:0];
    end else if (sum[SatW-1]) begin
      res = {1'b1, {(PosW - 1){1'b0}}};
    end else begin
      res = {1'b0, {(PosW - 1){1'b1}}};
    end
    return res;
  endfunction

  // Working registers, no reset needed.
  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    acc_x_q <= acc_next(cmd_i.x_op, acc_x_q, prod_acc, step_val);
    acc_y_q <= acc_next(cmd_i.y_op, acc_y_q, prod_acc, step_val);
    if (cmd_i.load) begin
      a_q    <= a_d;
      b_q    <= b_d;
      sum_q  <= sum_d;
      quad_q <= quad_d;
      cx_q   <= owo_pkg::CordicInvGain;
      cy_q   <= '0;
      cz_q   <= $signed(resid_d);
    end else if (cmd_i.cordic) begin
      if (!cz_q[TrigW-1]) begin
        cx_q <= cx_q - y_sh;
        cy_q <= cy_q + x_sh;
        cz_q <= cz_q - $signed(atan_val);
      end else begin
        cx_q <= cx_q + y_sh;
        cy_q <= cy_q - x_sh;
        cz_q <= cz_q + $signed(atan_val);
      end
    end else if (cmd_i.map) begin
      case (quad_q)
        2'd0: begin cx_q <= cx_q;  cy_q <= cy_q;  end
        2'd1: begin cx_q <= -cy_q; cy_q <= cx_q;  end
        2'd2: begin cx_q <= -cx_q; cy_q <= -cy_q; end
        default: begin cx_q <= cy_q; cy_q <= -cx_q; end
      endcase
    end
    if (cmd_i.out_load) begin
      ox_q <= px_q;
      oy_q <= py_q;
      oh_q <= hd_q;
    end
  end

  // Pose state, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
      hd_q <= '0;
    end else begin
      if (cmd_i.x_sat) begin
        px_q <= sat_add(px_q, acc_x_q);
      end
      if (cmd_i.y_sat) begin
        py_q <= sat_add(py_q, acc_y_q);
      end
      if (cmd_i.hd_upd) begin
        hd_q <= hd_q + prod_q[owo_pkg::AngW-1:0];
      end
    end
  end

  assign pos_x_o   = ox_q;
  assign pos_y_o   = oy_q;
  assign heading_o = oh_q;

endmodule

### tb/omni_wheel_odometry_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni_wheel_odometry_top_test: self-checking bench for the omni odometry block
// Walks a short table of directed wheel beats, then several random phases
// under different register settings, including a run that drives the
// position into its rails. A cycle-free pose predictor computes the expected
// x, y and heading of every accepted beat, and each result beat is compared
// with the oldest prediction. The sender idles and the result side stalls at random.
// ----------------------------------------------------------------------------
module omni_wheel_odometry_top_test;

  // Derived from the iteration count; sets the closing wait for stray beats.
  localparam int Latency    = owo_pkg::TrigIterationsDef + 12;
  localparam int TrigSteps  = owo_pkg::TrigIterationsDef;
  localparam int ArcCount   = 30;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int QuietLimit = 4000;
  // Length of the deliberate long hold-off on the result side.
  localparam int ParkCycles = 300;
  localparam int SteerRows  = 19;
  localparam int MaxPrinted = 50;

  // Arctangent of 2^-i in units of 2^-32 turn, used by the CORDIC predictor.
  localparam logic [31:0] ArcTurn [ArcCount] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
    32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051, 32'h0000_0029,
    32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0003, 32'h0000_0001
  };

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        hd;
  } pose_t;

  // A directed beat. Where fixed_result is set, the pose is typed in by hand.
  typedef struct packed {
    logic signed [15:0] w0;
    logic signed [15:0] w1;
    logic signed [15:0] w2;
    logic signed [15:0] w3;
    logic               fixed_result;
    logic [31:0]        ex;
    logic [31:0]        ey;
    logic [31:0]        eh;
  } steer_row_t;

  // --------------------------------------------------------------------------
  // Signals. Every input of the block starts at a known value.
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [15:0]       wheel0 = '0;
  logic signed [15:0]       wheel1 = '0;
  logic signed [15:0]       wheel2 = '0;
  logic signed [15:0]       wheel3 = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [31:0]       pos_x;
  logic signed [31:0]       pos_y;
  logic [31:0]              heading;

  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [2:0]               paddr   = '0;
  logic [31:0]              pwdata  = '0;
  logic [31:0]              prdata;
  logic                     pready;

  // Predictor state: the pose and a shadow of both registers.
  int                       model_x;
  int                       model_y;
  logic [31:0]              model_heading;
  logic [15:0]              model_dist;
  logic signed [20:0]       model_hstep;

  pose_t                    pending_poses [$];
  int                       mismatch_count = 0;
  int                       quiet_cycles   = 0;
  logic                     park_receiver  = 1'b0;

  always #5 clk = ~clk;

  omni_wheel_odometry_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .wheel0_delta_i (wheel0),
    .wheel1_delta_i (wheel1),
    .wheel2_delta_i (wheel2),
    .wheel3_delta_i (wheel3),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pos_x_o        (pos_x),
    .pos_y_o        (pos_y),
    .heading_o      (heading),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // --------------------------------------------------------------------------
  // Pose predictor.
  // --------------------------------------------------------------------------

  // Cosine and sine of a binary angle in Q1.30. The angle is first folded to
  // the nearest quadrant, the residual of at most an eighth of a turn goes
  // through the CORDIC rotation, and the quadrant is applied at the end.
  function automatic void unit_vector(input logic [31:0] ang,
                                      output longint c, output longint s);
    logic [31:0] lifted;
    logic [31:0] resid;
    logic [1:0]  quad;
    longint      x;
    longint      y;
    longint      z;
    longint      nx;
    lifted = ang + 32'h2000_0000;
    quad   = lifted[31:30];
    resid  = ang - {quad, 30'd0};
    z      = longint'(signed'(resid));
    x      = longint'(owo_pkg::CordicInvGain);
    y      = 0;
    for (int i = 0; i < TrigSteps && i < ArcCount; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ArcTurn[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ArcTurn[i]);
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  // Rotated count sum in Q30 to a position step in 2^-16 m, both roundings
  // half up.
  function automatic longint metres_step(input longint r30);
    longint r16;
    r16 = (r30 + (longint'(1) <<< 13)) >>> 14;
    return (r16 * longint'(model_dist) + (longint'(1) <<< 23)) >>> 24;
  endfunction

  // The position clamps at the 32-bit limits instead of wrapping.
  function automatic int rail_add(input int base, input longint step);
    longint sum;
    sum = longint'(base) + step;
    if (sum > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end
    if (sum < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return int'(sum);
  endfunction

  // Moves the predicted pose by one wheel beat and returns the new pose.
  // The position uses the heading from before the beat.
  function automatic pose_t advance_pose(input logic signed [15:0] w0,
                                         input logic signed [15:0] w1,
                                         input logic signed [15:0] w2,
                                         input logic signed [15:0] w3);
    longint a;
    longint b;
    longint c;
    longint s;
    longint turn;
    pose_t  nxt;
    a = longint'(w0) - longint'(w2);
    b = longint'(w1) - longint'(w3);
    unit_vector(model_heading, c, s);
    model_x = rail_add(model_x, metres_step(a * c - b * s));
    model_y = rail_add(model_y, metres_step(a * s + b * c));
    turn = (longint'(w0) + longint'(w1) + longint'(w2) + longint'(w3))
           * longint'(model_hstep);
    model_heading = model_heading + 32'(turn);
    nxt.x  = model_x;
    nxt.y  = model_y;
    nxt.hd = model_heading;
    return nxt;
  endfunction

  // --------------------------------------------------------------------------
  // Checking.
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  // Every result beat is matched against the oldest pending prediction.
  always @(posedge clk) begin : check_results
    pose_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_poses.size() == 0) begin
        note_mismatch("result beat with no prediction", pos_x, 32'd0);
      end else begin
        want = pending_poses.pop_front();
        if (pos_x !== want.x) begin
          note_mismatch("pos_x", pos_x, want.x);
        end
        if (pos_y !== want.y) begin
          note_mismatch("pos_y", pos_y, want.y);
        end
        if (heading !== want.hd) begin
          note_mismatch("heading", heading, want.hd);
        end
      end
    end
  end

  // Watchdog: any accepted beat on either channel or a register access
  // restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("omni_wheel_odometry_top_test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, mostly short with a few long ones, and runs
  // without any stall. A park request from the stimulus holds the channel
  // off for a long stretch so that the block backs up into its input.
  // --------------------------------------------------------------------------
  initial begin : result_stalls
    int pick;
    int span;
    wait (rst_n);
    @(posedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (park_receiver) begin
        park_receiver = 1'b0;
        out_stall <= 1'b1;
        span = ParkCycles;
      end else if (pick < 60) begin
        out_stall <= 1'b0;
        span = $urandom_range(1, 12);
      end else if (pick < 70) begin
        out_stall <= 1'b0;
        span = $urandom_range(40, 120);
      end else if (pick < 95) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 4);
      end else begin
        out_stall <= 1'b1;
        span = $urandom_range(15, 50);
      end
      repeat (span) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered right after a rising edge.
  // --------------------------------------------------------------------------

  // Offers one wheel beat, holds it until accepted, then records the pose
  // it must produce.
  task automatic offer_beat(input logic signed [15:0] w0, input logic signed [15:0] w1,
                            input logic signed [15:0] w2, input logic signed [15:0] w3,
                            input logic fixed_result, input pose_t fixed_pose);
    pose_t predicted;
    wheel0   <= w0;
    wheel1   <= w1;
    wheel2   <= w2;
    wheel3   <= w3;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = advance_pose(w0, w1, w2, w3);
    pending_poses.push_back(fixed_result ? fixed_pose : predicted);
  endtask

  // Random gap after a beat: half of the time none, mostly a few cycles,
  // now and then a long one.
  task automatic sender_pause();
    int pick;
    int span;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      span = 0;
    end else if (pick < 90) begin
      span = $urandom_range(1, 4);
    end else begin
      span = $urandom_range(15, 60);
    end
    if (span > 0) begin
      in_valid <= 1'b0;
      repeat (span) @(posedge clk);
    end
  endtask

  // Stops offering and waits for every predicted result to come out.
  task automatic settle_block();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_poses.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read_check(input logic idx, input logic [31:0] want,
                                input logic [31:0] mask);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) !== (want & mask)) begin
      note_mismatch("register read back", got & mask, want & mask);
    end
    @(posedge clk);
  endtask

  // Registers change only with the block idle. Each write is read back.
  task automatic program_regs(input logic [15:0] scale_val, input logic signed [20:0] hstep);
    settle_block();
    apb_write(owo_pkg::RegDistanceScale, {16'd0, scale_val});
    apb_write(owo_pkg::RegHeadingStep, 32'(hstep));
    model_dist  = scale_val;
    model_hstep = hstep;
    apb_read_check(owo_pkg::RegDistanceScale, {16'd0, scale_val}, 32'h0000_FFFF);
    apb_read_check(owo_pkg::RegHeadingStep, 32'(hstep), 32'h001F_FFFF);
  endtask

  // A wheel delta: full range, small, the extremes, or moderate.
  function automatic logic signed [15:0] pick_delta();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom);
      4, 5, 6:    return 16'($urandom_range(0, 127)) - 16'sd64;
      7: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return -16'sd1;
          3:       return 16'sd0;
          default: return 16'sd1;
        endcase
      end
      default:    return 16'($urandom_range(0, 4095)) - 16'sd2048;
    endcase
  endfunction

  // Random phase. At park_at the result side is parked and the next dozen
  // beats go out back to back; at drain_at the sender waits for every
  // result. A negative index leaves that event out.
  task automatic run_random(input int count, input int park_at, input int drain_at);
    logic signed [15:0] w0;
    logic signed [15:0] w1;
    logic signed [15:0] w2;
    logic signed [15:0] w3;
    for (int i = 0; i < count; i++) begin
      if (i == park_at) begin
        park_receiver = 1'b1;
      end
      if (i == drain_at) begin
        settle_block();
      end
      w0 = pick_delta();
      w1 = pick_delta();
      w2 = pick_delta();
      w3 = pick_delta();
      // Some beats only spin the robot on the spot.
      if ($urandom_range(0, 5) == 0) begin
        w2 = w0;
        w3 = w1;
      end
      offer_beat(w0, w1, w2, w3, 1'b0, '0);
      if (park_at < 0 || i < park_at || i >= park_at + 12) begin
        sender_pause();
      end
    end
  endtask

  // Near-maximal opposite wheel pairs at full scale and fixed heading: every
  // beat moves the robot by roughly the largest step, so the position runs
  // into its limits and has to stay there.
  task automatic run_to_rails(input int count);
    logic signed [15:0] w0;
    logic signed [15:0] w1;
    logic signed [15:0] w2;
    logic signed [15:0] w3;
    for (int i = 0; i < count; i++) begin
      w0 = 16'($urandom_range(30000, 32767));
      w2 = -16'($urandom_range(30000, 32768));
      w1 = -16'($urandom_range(30000, 32768));
      w3 = 16'($urandom_range(30000, 32767));
      offer_beat(w0, w1, w2, w3, 1'b0, '0);
      sender_pause();
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed beats at the reset settings. The first three are typed in: an
  // all-zero beat leaves the pose at zero, and beats with equal opposite
  // wheels only turn the heading, by twice the reset step each, wrapping
  // below zero on the first turn.
  // --------------------------------------------------------------------------
  steer_row_t steer_rows [SteerRows] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 32'd0, 32'd0, 32'd0},
    '{16'sd1, 16'sd0, 16'sd1, 16'sd0, 1'b1, 32'd0, 32'd0, 32'hFFFB_A184},
    '{16'sd0, 16'sd1, 16'sd0, 16'sd1, 1'b1, 32'd0, 32'd0, 32'hFFF7_4308},
    '{16'sd32767, 16'sd0, -16'sd32768, 16'sd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 1'b0, 32'd0, 32'd0, 32'd0},
    '{-16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{16'sd0, -16'sd32768, 16'sd0, 16'sd32767, 1'b0, 32'd0, 32'd0, 32'd0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 32'd0, 32'd0, 32'd0},
    '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 32'd0, 32'd0, 32'd0},
    '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, 32'd0, 32'd0, 32'd0},
    '{16'sd1, 16'sd2, 16'sd3, 16'sd4, 1'b0, 32'd0, 32'd0, 32'd0},
    '{16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{16'sd100, -16'sd100, -16'sd100, 16'sd100, 1'b0, 32'd0, 32'd0, 32'd0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 32'd0, 32'd0, 32'd0},
    '{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1'b0, 32'd0, 32'd0, 32'd0},
    '{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 1'b0, 32'd0, 32'd0, 32'd0},
    '{16'sd12345, -16'sd2222, -16'sd7777, 16'sd31000, 1'b0, 32'd0, 32'd0, 32'd0},
    '{16'sd2500, 16'sd2500, 16'sd2500, 16'sd2500, 1'b0, 32'd0, 32'd0, 32'd0},
    '{-16'sd9, 16'sd7, -16'sd5, 16'sd3, 1'b0, 32'd0, 32'd0, 32'd0}
  };

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    pose_t fixed_pose;
    model_x       = 0;
    model_y       = 0;
    model_heading = '0;
    model_dist    = owo_pkg::DistanceScaleReset;
    model_hstep   = owo_pkg::HeadingStepReset;

    // Reset is held at the start and never asserted again.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table at the reset settings.
    for (int r = 0; r < SteerRows; r++) begin
      fixed_pose.x  = steer_rows[r].ex;
      fixed_pose.y  = steer_rows[r].ey;
      fixed_pose.hd = steer_rows[r].eh;
      offer_beat(steer_rows[r].w0, steer_rows[r].w1, steer_rows[r].w2, steer_rows[r].w3,
                 steer_rows[r].fixed_result, fixed_pose);
      sender_pause();
    end

    // Random beats at the reset settings, with the long hold-off on the
    // result side partway through.
    run_random(60, 20, -1);

    // Full distance scale, heading frozen: drive the position into its rails.
    program_regs(16'hFFFF, 21'sd0);
    run_to_rails(170);

    // Zero distance freezes the position; the most negative turn step.
    program_regs(16'h0000, -21'sd1048576);
    run_random(55, -1, -1);

    // Smallest nonzero distance; the most positive turn step.
    program_regs(16'h0001, 21'sd1048575);
    run_random(55, -1, -1);

    // Random settings, with a full drain of the block partway through.
    program_regs(16'($urandom), 21'($urandom));
    run_random(55, -1, 25);

    // Let every result come out, then give the block time to show any
    // stray beat.
    settle_block();
    repeat (2 * Latency) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("omni_wheel_odometry_top_test passed");
    end else begin
      $display("omni_wheel_odometry_top_test failed");
    end
    $finish;
  end

endmodule
